/* rtl/bglu_pkg.sv */
`default_nettype none

package bglu_pkg;

  localparam int unsigned OPERAND_WIDTH = 32;
  localparam int unsigned SHIFT_W = $clog2(OPERAND_WIDTH);
  localparam int unsigned CNT_W = $clog2(OPERAND_WIDTH);
  localparam int unsigned STEP_W = 4;

  typedef logic [OPERAND_WIDTH-1:0] operand_t;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    operand_t first_operand;
    operand_t second_operand;
  } in_beat_t;

  typedef struct packed {
    operand_t divisor_result;
    operand_t multiple_result;
    logic     multiple_overflow;
  } out_beat_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SHR_COMMON,
    OP_SHR_A,
    OP_SHR_B,
    OP_SWAP_SUB,
    OP_G_FROM_A,
    OP_G_FROM_B,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_WRITE_OUT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_BEAT_IN,
    C_A_ZERO,
    C_B_ZERO,
    C_BOTH_EVEN,
    C_A_EVEN,
    C_B_EVEN,
    C_B_NONZERO,
    C_CNT_MORE,
    C_OUT_BUSY
  } cond_e;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_CHK_A    = 4'd1;
  localparam step_t STEP_CHK_B    = 4'd2;
  localparam step_t STEP_COMMON   = 4'd3;
  localparam step_t STEP_STRIP_A  = 4'd4;
  localparam step_t STEP_STRIP_B  = 4'd5;
  localparam step_t STEP_SUB      = 4'd6;
  localparam step_t STEP_TEST_B   = 4'd7;
  localparam step_t STEP_G_FROM_A = 4'd8;
  localparam step_t STEP_G_FROM_B = 4'd9;
  localparam step_t STEP_DIV_INIT = 4'd10;
  localparam step_t STEP_DIV      = 4'd11;
  localparam step_t STEP_MUL_INIT = 4'd12;
  localparam step_t STEP_MUL      = 4'd13;
  localparam step_t STEP_FINISH   = 4'd14;
  localparam step_t STEP_RESTART  = 4'd15;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic a_zero;
    logic b_zero;
    logic a_even;
    logic b_even;
    logic cnt_last;
  } status_t;

  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t word;
    unique case (step)
      STEP_IDLE:     word = '{op: OP_LOAD,       cond: C_NO_BEAT_IN, target: STEP_IDLE};
      STEP_CHK_A:    word = '{op: OP_NOP,        cond: C_A_ZERO,     target: STEP_G_FROM_B};
      STEP_CHK_B:    word = '{op: OP_NOP,        cond: C_B_ZERO,     target: STEP_G_FROM_A};
      STEP_COMMON:   word = '{op: OP_SHR_COMMON, cond: C_BOTH_EVEN,  target: STEP_COMMON};
      STEP_STRIP_A:  word = '{op: OP_SHR_A,      cond: C_A_EVEN,     target: STEP_STRIP_A};
      STEP_STRIP_B:  word = '{op: OP_SHR_B,      cond: C_B_EVEN,     target: STEP_STRIP_B};
      STEP_SUB:      word = '{op: OP_SWAP_SUB,   cond: C_NEVER,      target: STEP_IDLE};
      STEP_TEST_B:   word = '{op: OP_NOP,        cond: C_B_NONZERO,  target: STEP_STRIP_B};
      STEP_G_FROM_A: word = '{op: OP_G_FROM_A,   cond: C_ALWAYS,     target: STEP_DIV_INIT};
      STEP_G_FROM_B: word = '{op: OP_G_FROM_B,   cond: C_NEVER,      target: STEP_IDLE};
      STEP_DIV_INIT: word = '{op: OP_DIV_INIT,   cond: C_NEVER,      target: STEP_IDLE};
      STEP_DIV:      word = '{op: OP_DIV_STEP,   cond: C_CNT_MORE,   target: STEP_DIV};
      STEP_MUL_INIT: word = '{op: OP_MUL_INIT,   cond: C_NEVER,      target: STEP_IDLE};
      STEP_MUL:      word = '{op: OP_MUL_STEP,   cond: C_CNT_MORE,   target: STEP_MUL};
      STEP_FINISH:   word = '{op: OP_WRITE_OUT,  cond: C_OUT_BUSY,   target: STEP_FINISH};
      STEP_RESTART:  word = '{op: OP_NOP,        cond: C_ALWAYS,     target: STEP_IDLE};
      default:       word = '{op: OP_NOP,        cond: C_ALWAYS,     target: STEP_IDLE};
    endcase
    return word;
  endfunction

endpackage

`default_nettype wire

/* rtl/bglu_sequencer.sv */
`default_nettype none

module bglu_sequencer
  import bglu_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire status_t status_i,
  output      ctrl_t   ctrl_o,
  output      logic    in_ready_o
);

  step_t step_q;
  step_t step_d;
  ctrl_t word;
  logic  take;

  always_comb begin
    word = ucode_rom(step_q);
    unique case (word.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_BEAT_IN: take = !status_i.in_valid;
      C_A_ZERO:     take = status_i.a_zero;
      C_B_ZERO:     take = status_i.b_zero;
      C_BOTH_EVEN:  take = status_i.a_even && status_i.b_even;
      C_A_EVEN:     take = status_i.a_even;
      C_B_EVEN:     take = status_i.b_even;
      C_B_NONZERO:  take = !status_i.b_zero;
      C_CNT_MORE:   take = !status_i.cnt_last;
      C_OUT_BUSY:   take = status_i.out_busy;
      default:      take = 1'b1;
    endcase
    step_d = take ? word.target : step_q + step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o     = word;
  assign in_ready_o = (step_q == STEP_IDLE);

endmodule

`default_nettype wire

/* rtl/bglu_datapath.sv */
`default_nettype none

module bglu_datapath
  import bglu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ctrl_t     ctrl_i,
  input  wire logic      in_valid_i,
  input  wire in_beat_t  in_beat_i,
  input  wire logic      out_ready_i,
  output      status_t   status_o,
  output      logic      out_valid_o,
  output      out_beat_t out_beat_o
);

  localparam int unsigned W = OPERAND_WIDTH;

  operand_t             a_q, a_d, b_q, b_d;
  logic [SHIFT_W-1:0]   k_q, k_d;
  operand_t             g_q, g_d;
  operand_t             big_q, big_d, small_q, small_d;
  operand_t             rem_q, rem_d, quo_q, quo_d;
  operand_t             hi_q, hi_d, lo_q, lo_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_q, out_d;

  logic                 out_busy;
  logic                 a_even, b_even;
  logic [W:0]           rem_sh;
  logic [W+1:0]         diff;
  logic [W:0]           sum;

  assign out_busy = out_valid_q && !out_ready_i;
  assign a_even   = !a_q[0];
  assign b_even   = !b_q[0];
  assign rem_sh   = {rem_q, quo_q[W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, g_q};
  assign sum      = {1'b0, hi_q} + (lo_q[0] ? {1'b0, small_q} : {(W+1){1'b0}});

  always_comb begin
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    g_d         = g_q;
    big_d       = big_q;
    small_d     = small_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (ctrl_i.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        if (in_valid_i) begin
          a_d = in_beat_i.first_operand;
          b_d = in_beat_i.second_operand;
          k_d = '0;
          if (in_beat_i.first_operand > in_beat_i.second_operand) begin
            big_d   = in_beat_i.first_operand;
            small_d = in_beat_i.second_operand;
          end else begin
            big_d   = in_beat_i.second_operand;
            small_d = in_beat_i.first_operand;
          end
        end
      end
      OP_SHR_COMMON: begin
        if (a_even && b_even) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + SHIFT_W'(1);
        end
      end
      OP_SHR_A: begin
        if (a_even) begin
          a_d = a_q >> 1;
        end
      end
      OP_SHR_B: begin
        if (b_even) begin
          b_d = b_q >> 1;
        end
      end
      OP_SWAP_SUB: begin
        if (a_q > b_q) begin
          a_d = b_q;
          b_d = a_q - b_q;
        end else begin
          b_d = b_q - a_q;
        end
      end
      OP_G_FROM_A: g_d = a_q << k_q;
      OP_G_FROM_B: g_d = b_q;
      OP_DIV_INIT: begin
        rem_d = '0;
        quo_d = big_q;
        cnt_d = '0;
      end
      OP_DIV_STEP: begin
        if (!diff[W+1]) begin
          rem_d = diff[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
      end
      OP_MUL_INIT: begin
        hi_d  = '0;
        lo_d  = quo_q;
        cnt_d = '0;
      end
      OP_MUL_STEP: begin
        hi_d  = sum[W:1];
        lo_d  = {sum[0], lo_q[W-1:1]};
        cnt_d = cnt_q + CNT_W'(1);
      end
      OP_WRITE_OUT: begin
        if (!out_busy) begin
          out_d.divisor_result    = g_q;
          out_d.multiple_result   = lo_q;
          out_d.multiple_overflow = (hi_q != '0);
          out_valid_d             = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      k_q         <= '0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    g_q     <= g_d;
    big_q   <= big_d;
    small_q <= small_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    out_q   <= out_d;
  end

  always_comb begin
    status_o.in_valid = in_valid_i;
    status_o.out_busy = out_busy;
    status_o.a_zero   = (a_q == '0);
    status_o.b_zero   = (b_q == '0);
    status_o.a_even   = a_even;
    status_o.b_even   = b_even;
    status_o.cnt_last = (cnt_q == CNT_W'(W - 1));
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

`default_nettype wire

/* rtl/binary_gcd_lcm_unit.sv */
// Greatest common divisor and least common multiple of two unsigned operands.
// An input beat carries both operands on in_beat_i and is taken when in_valid_i
// and in_ready_o are both high; an output beat carries the divisor, the low
// bits of the multiple and an overflow flag, and leaves when out_valid_o and
// out_ready_i are both high. One result beat follows every input beat.
// A microcode table of sixteen steps drives a single datapath: the binary
// divisor loop, then a restoring divider giving the larger operand over the
// divisor one bit a cycle, then a shift-and-add multiplier one bit a cycle.
// The time an item takes depends on the data: the binary shift and subtract
// loop runs for as long as the operands need and is skipped when an operand
// is zero; the divide and the multiply then follow. One item is worked on
// at a time and in_ready_o is high only while the sequencer waits at its
// first step.
// The finished result sits in an output register, so the next input beat is
// taken while it waits. If the receiver stalls while a second result is
// ready, the sequencer holds at its finish step until the register frees.
// Reset returns the sequencer to its first step and empties the output.
`default_nettype none

module binary_gcd_lcm_unit
  import bglu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_ready_o,
  input  wire in_beat_t  in_beat_i,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      out_beat_t out_beat_o
);

  ctrl_t   ctrl;
  status_t status;

  bglu_sequencer u_sequencer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .in_ready_o (in_ready_o)
  );

  bglu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (in_valid_i),
    .in_beat_i   (in_beat_i),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire
